/* design/imhdk_pkg.sv */
package imhdk_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int KEY_W         = 64;
    localparam int TGT_W         = 11;
    localparam int AMT_W         = 63;

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_DECREASE = 2'd1,
        FUNC_GET_MIN  = 2'd2,
        FUNC_EXTRACT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_NOT_LIVE = 2'd3
    } status_t;

    typedef struct packed {
        func_t                    func;
        logic signed [KEY_W-1:0]  key;
        logic [TGT_W-1:0]         target_item;
        logic [AMT_W-1:0]         decrease_amount;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  min_key;
        status_t                  status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_DEC_CHK, ST_DEC_SUB, ST_UP_RD, ST_UP_CMP, ST_GET,
        ST_EXT_A, ST_EXT_B, ST_DN_RD1, ST_DN_RD2, ST_DN_PICK, ST_DN_CMP, ST_PLACE,
        ST_FILL, ST_OUT
    } state_t;

    // Read address choice for the key and handle memories.
    typedef enum logic [2:0] {
        RD_ROOT, RD_SLOT, RD_PARENT, RD_LAST, RD_CHILD, RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE, WR_UP_MOVE, WR_DN_MOVE, WR_PLACE
    } wr_sel_t;

    typedef enum logic [1:0] {
        LIVE_NONE, LIVE_CLEAR, LIVE_FILL
    } live_op_t;

    typedef struct packed {
        logic      load;
        logic      kh_rd;
        rd_sel_t   rd_sel;
        logic      tl_rd;
        wr_sel_t   wr_sel;
        live_op_t  live_op;
        logic      set_status;
        status_t   status;
        logic      ins_setup;
        logic      pos_from_slot;
        logic      dec_apply;
        logic      ext_shrink;
        logic      ext_take_last;
        logic      dn_child;
        logic      dn_best_first;
        logic      dn_best_pick;
        logic      get_latch;
        logic      fill;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        func_t  func;
        logic   count_zero;
        logic   last_zero;
        logic   ins_full;
        logic   tgt_bad;
        logic   live_ok;
        logic   pos_zero;
        logic   child_out;
        logic   right_ok;
        logic   parent_gt;
        logic   best_lt;
        logic   out_free;
    } stat_t;

endpackage

/* design/indexed_min_heap_decrease_key_core.sv */
// An error found at dispatch, a get-min, a decrease of a handle that is not live and an extract
// that empties the heap finish without a sift. Insert and decrease sift up and extract-min sifts
// down, one heap level per pass, over at most clog2(MAX_ITEMS) levels (10 at the default size).
// The core takes one item at a time: a new input is accepted only once the result of the last
// is loaded into the output register, which waits while that register is still full.
// Reset (aresetn, synchronous, active low) empties the heap and the item counter; memories are
// not cleared, and handle liveness past the item counter reads as not live.
module indexed_min_heap_decrease_key_core import imhdk_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    // The controller walks each operation through its steps: check, then a sift that
    // moves a hole up or down the tree one level per pass, then a final placement.
    // The datapath owns the heap memories, the counters and the result registers.
    // An input transfer is taken only when the controller is idle; the finished result
    // sits in an output register so a new input can be accepted while it waits.
    cmd_t  cmd;
    stat_t stat;

    imhdk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Each of the first MAX_ITEMS items writes the liveness bit of its own item number, so
    // entries below the counter are always written and those at or above it read as not live.
    imhdk_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* design/imhdk_ram.sv */
module imhdk_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/imhdk_ctrl.sv */
module imhdk_ctrl import imhdk_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.func)
                    FUNC_INSERT: begin
                        if (stat.ins_full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_FULL;
                            state_next     = ST_FILL;
                        end else begin
                            cmd.ins_setup = 1'b1;
                            state_next    = ST_UP_RD;
                        end
                    end
                    FUNC_DECREASE: begin
                        if (stat.tgt_bad) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_NOT_LIVE;
                            state_next     = ST_FILL;
                        end else begin
                            cmd.tl_rd  = 1'b1;
                            state_next = ST_DEC_CHK;
                        end
                    end
                    FUNC_GET_MIN: begin
                        if (stat.count_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_EMPTY;
                            state_next     = ST_FILL;
                        end else begin
                            cmd.kh_rd  = 1'b1;
                            cmd.rd_sel = RD_ROOT;
                            state_next = ST_GET;
                        end
                    end
                    default: begin
                        if (stat.count_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_EMPTY;
                            state_next     = ST_FILL;
                        end else begin
                            cmd.kh_rd  = 1'b1;
                            cmd.rd_sel = RD_ROOT;
                            state_next = ST_EXT_A;
                        end
                    end
                endcase
            end
            ST_DEC_CHK: begin
                if (!stat.live_ok) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_NOT_LIVE;
                    state_next     = ST_FILL;
                end else begin
                    cmd.pos_from_slot = 1'b1;
                    cmd.kh_rd         = 1'b1;
                    cmd.rd_sel        = RD_SLOT;
                    state_next        = ST_DEC_SUB;
                end
            end
            ST_DEC_SUB: begin
                cmd.dec_apply = 1'b1;
                state_next    = ST_UP_RD;
            end
            ST_UP_RD: begin
                if (stat.pos_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.kh_rd  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.parent_gt) begin
                    cmd.wr_sel = WR_UP_MOVE;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_GET: begin
                cmd.get_latch = 1'b1;
                state_next    = ST_FILL;
            end
            ST_EXT_A: begin
                cmd.live_op    = LIVE_CLEAR;
                cmd.ext_shrink = 1'b1;
                if (stat.last_zero) begin
                    state_next = ST_FILL;
                end else begin
                    cmd.kh_rd  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_EXT_B;
                end
            end
            ST_EXT_B: begin
                cmd.ext_take_last = 1'b1;
                state_next        = ST_DN_RD1;
            end
            ST_DN_RD1: begin
                if (stat.child_out) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.kh_rd    = 1'b1;
                    cmd.rd_sel   = RD_CHILD;
                    cmd.dn_child = 1'b1;
                    state_next   = ST_DN_RD2;
                end
            end
            ST_DN_RD2: begin
                cmd.dn_best_first = 1'b1;
                if (stat.right_ok) begin
                    cmd.kh_rd  = 1'b1;
                    cmd.rd_sel = RD_RIGHT;
                    state_next = ST_DN_PICK;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_PICK: begin
                cmd.dn_best_pick = 1'b1;
                state_next       = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (stat.best_lt) begin
                    cmd.wr_sel = WR_DN_MOVE;
                    state_next = ST_DN_RD1;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.wr_sel = WR_PLACE;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd.fill    = 1'b1;
                cmd.live_op = LIVE_FILL;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/imhdk_dp.sv */
module imhdk_dp import imhdk_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  cmd_t       cmd,
    output stat_t      stat,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CW    = IDX_W + 2;

    in_item_t                 item_reg, item_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ctr_reg, ctr_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic signed [KEY_W-1:0]  cur_key_reg, cur_key_next;
    logic [IDX_W-1:0]         cur_hdl_reg, cur_hdl_next;
    logic [IDX_W-1:0]         child_reg, child_next;
    logic signed [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [IDX_W-1:0]         best_hdl_reg, best_hdl_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic                     ins_ok_reg, ins_ok_next;
    out_item_t                res_reg, res_next;
    out_item_t                m_data_reg, m_data_next;
    logic                     m_valid_reg, m_valid_next;

    logic [KEY_W-1:0]  keys_rd;
    logic [IDX_W-1:0]  hdl_rd;
    logic [IDX_W-1:0]  slot_rd;
    logic [0:0]        live_rd;

    logic [IDX_W-1:0]  kh_addr;
    logic              kh_we;
    logic [IDX_W-1:0]  kh_wr_addr;
    logic [KEY_W-1:0]  key_wr;
    logic [IDX_W-1:0]  hdl_wr;
    logic [IDX_W-1:0]  slot_wr_addr;
    logic              live_we;
    logic [IDX_W-1:0]  live_wr_addr;
    logic [0:0]        live_wr;

    logic [IDX_W-1:0]  tgt_idx;
    logic [IDX_W-1:0]  parent_idx;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W:0]    child_full;
    logic [IDX_W-1:0]  right_idx;
    logic              ctr_open;
    logic [KEY_W:0]    dec_diff;
    logic signed [KEY_W-1:0] dec_key;

    assign tgt_idx    = IDX_W'(32'(item_reg.target_item) - 32'd1);
    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign child_full = {pos_reg, 1'b1};
    assign right_idx  = child_reg + IDX_W'(1);
    assign ctr_open   = (ctr_reg < CNT_W'(MAX_ITEMS));

    // Saturating subtract: overflow shows as a disagreement of the two top bits.
    assign dec_diff = {keys_rd[KEY_W-1], keys_rd} - {2'b00, item_reg.decrease_amount};
    assign dec_key  = (dec_diff[KEY_W] != dec_diff[KEY_W-1])
                    ? {1'b1, {(KEY_W-1){1'b0}}} : $signed(dec_diff[KEY_W-1:0]);

    always_comb begin
        case (cmd.rd_sel)
            RD_ROOT:   kh_addr = '0;
            RD_SLOT:   kh_addr = slot_rd;
            RD_PARENT: kh_addr = parent_idx;
            RD_LAST:   kh_addr = last_idx;
            RD_CHILD:  kh_addr = child_full[IDX_W-1:0];
            RD_RIGHT:  kh_addr = right_idx;
            default:   kh_addr = '0;
        endcase
    end

    always_comb begin
        kh_we        = 1'b0;
        kh_wr_addr   = pos_reg;
        key_wr       = cur_key_reg;
        hdl_wr       = cur_hdl_reg;
        slot_wr_addr = cur_hdl_reg;
        case (cmd.wr_sel)
            WR_UP_MOVE: begin
                kh_we        = 1'b1;
                key_wr       = keys_rd;
                hdl_wr       = hdl_rd;
                slot_wr_addr = hdl_rd;
            end
            WR_DN_MOVE: begin
                kh_we        = 1'b1;
                key_wr       = best_key_reg;
                hdl_wr       = best_hdl_reg;
                slot_wr_addr = best_hdl_reg;
            end
            WR_PLACE: begin
                kh_we = 1'b1;
            end
            default: begin
                kh_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        live_we      = 1'b0;
        live_wr_addr = ctr_reg[IDX_W-1:0];
        live_wr      = ins_ok_reg;
        case (cmd.live_op)
            LIVE_CLEAR: begin
                live_we      = 1'b1;
                live_wr_addr = hdl_rd;
                live_wr      = 1'b0;
            end
            LIVE_FILL: begin
                live_we = ctr_open;
            end
            default: begin
                live_we = 1'b0;
            end
        endcase
    end

    imhdk_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_keys (
        .aclk(aclk), .wr_en(kh_we), .wr_addr(kh_wr_addr), .wr_data(key_wr),
        .rd_en(cmd.kh_rd), .rd_addr(kh_addr), .rd_data(keys_rd)
    );

    imhdk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_handles (
        .aclk(aclk), .wr_en(kh_we), .wr_addr(kh_wr_addr), .wr_data(hdl_wr),
        .rd_en(cmd.kh_rd), .rd_addr(kh_addr), .rd_data(hdl_rd)
    );

    imhdk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_slots (
        .aclk(aclk), .wr_en(kh_we), .wr_addr(slot_wr_addr), .wr_data(pos_reg),
        .rd_en(cmd.tl_rd), .rd_addr(tgt_idx), .rd_data(slot_rd)
    );

    imhdk_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_live (
        .aclk(aclk), .wr_en(live_we), .wr_addr(live_wr_addr), .wr_data(live_wr),
        .rd_en(cmd.tl_rd), .rd_addr(tgt_idx), .rd_data(live_rd)
    );

    always_comb begin
        item_next     = cmd.load ? s_data : item_reg;
        count_next    = count_reg;
        ctr_next      = ctr_reg;
        pos_next      = pos_reg;
        cur_key_next  = cur_key_reg;
        cur_hdl_next  = cur_hdl_reg;
        child_next    = child_reg;
        best_key_next = best_key_reg;
        best_hdl_next = best_hdl_reg;
        best_idx_next = best_idx_reg;
        ins_ok_next   = ins_ok_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cmd.load) begin
            ins_ok_next = 1'b0;
            res_next    = '{min_key: '0, status: STATUS_OK};
        end
        if (cmd.set_status) begin
            res_next.status = cmd.status;
        end
        if (cmd.ins_setup) begin
            cur_key_next = item_reg.key;
            cur_hdl_next = ctr_reg[IDX_W-1:0];
            pos_next     = IDX_W'(count_reg);
            count_next   = count_reg + CNT_W'(1);
            ins_ok_next  = 1'b1;
        end
        if (cmd.pos_from_slot) begin
            pos_next     = slot_rd;
            cur_hdl_next = tgt_idx;
        end
        if (cmd.dec_apply) begin
            cur_key_next = dec_key;
        end
        if (cmd.ext_shrink) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.ext_take_last) begin
            cur_key_next = $signed(keys_rd);
            cur_hdl_next = hdl_rd;
            pos_next     = '0;
        end
        if (cmd.dn_child) begin
            child_next = child_full[IDX_W-1:0];
        end
        if (cmd.dn_best_first) begin
            best_key_next = $signed(keys_rd);
            best_hdl_next = hdl_rd;
            best_idx_next = child_reg;
        end
        if (cmd.dn_best_pick && ($signed(keys_rd) < best_key_reg)) begin
            best_key_next = $signed(keys_rd);
            best_hdl_next = hdl_rd;
            best_idx_next = right_idx;
        end
        if (cmd.wr_sel == WR_UP_MOVE) begin
            pos_next = parent_idx;
        end
        if (cmd.wr_sel == WR_DN_MOVE) begin
            pos_next = best_idx_reg;
        end
        if (cmd.get_latch) begin
            res_next.min_key = $signed(keys_rd);
        end
        if (cmd.fill && ctr_open) begin
            ctr_next = ctr_reg + CNT_W'(1);
        end
        if (cmd.out_load) begin
            m_data_next  = res_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ctr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ctr_reg     <= ctr_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg     <= item_next;
        pos_reg      <= pos_next;
        cur_key_reg  <= cur_key_next;
        cur_hdl_reg  <= cur_hdl_next;
        child_reg    <= child_next;
        best_key_reg <= best_key_next;
        best_hdl_reg <= best_hdl_next;
        best_idx_reg <= best_idx_next;
        ins_ok_reg   <= ins_ok_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.func       = item_reg.func;
        stat.count_zero = (count_reg == '0);
        stat.last_zero  = (count_reg == CNT_W'(1));
        stat.ins_full   = !ctr_open || (count_reg >= CNT_W'(MAX_ITEMS));
        stat.tgt_bad    = (item_reg.target_item == '0)
                        || (32'(item_reg.target_item) > 32'(MAX_ITEMS))
                        || ((32'(item_reg.target_item) - 32'd1) >= 32'(ctr_reg));
        stat.live_ok    = live_rd[0];
        stat.pos_zero   = (pos_reg == '0);
        stat.child_out  = (CW'(child_full) >= CW'(count_reg));
        stat.right_ok   = ((CW'(child_reg) + CW'(1)) < CW'(count_reg));
        stat.parent_gt  = ($signed(keys_rd) > cur_key_reg);
        stat.best_lt    = (best_key_reg < cur_key_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("heap count above capacity");

    a_ctr_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ctr_reg >= $past(ctr_reg))
        else $error("item counter went backwards");

    a_count_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins_setup || cmd.ext_shrink) |=> $stable(count_reg))
        else $error("heap count changed without insert or extract");

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imhdk_pkg::*;

    localparam int HEAP_DEPTH = MAX_ITEMS_DEF;
    localparam int IDLE_LIMIT = 5000;

    // Scoreboard that mirrors the indexed heap and holds expected results in arrival order.
    class heap_scoreboard;
        longint    slot_key[HEAP_DEPTH];
        int        slot_handle[HEAP_DEPTH];
        int        handle_pos[HEAP_DEPTH];
        bit        handle_in_heap[HEAP_DEPTH];
        int        occupied;
        int        items_seen;
        out_item_t pending_results[$];
        int        mismatches;

        function void swap_slots(int a, int b);
            longint k;
            int     h;
            k = slot_key[a];
            h = slot_handle[a];
            slot_key[a] = slot_key[b];
            slot_handle[a] = slot_handle[b];
            slot_key[b] = k;
            slot_handle[b] = h;
            handle_pos[slot_handle[a]] = a;
            handle_pos[slot_handle[b]] = b;
        endfunction

        function void sift_up(int pos);
            int parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (slot_key[parent] <= slot_key[pos]) break;
                swap_slots(parent, pos);
                pos = parent;
            end
        endfunction

        function void sift_down(int pos);
            int child;
            forever begin
                child = 2 * pos + 1;
                if (child >= occupied) break;
                if (child + 1 < occupied && slot_key[child + 1] < slot_key[child]) child++;
                if (slot_key[child] >= slot_key[pos]) break;
                swap_slots(child, pos);
                pos = child;
            end
        endfunction

        // Applies one accepted input to the mirrored heap and queues its result.
        function void note_input(in_item_t it);
            out_item_t r;
            int        pos;
            int        last;
            longint    k;
            longint    amt;
            r.min_key = '0;
            r.status  = STATUS_OK;
            amt = longint'({1'b0, it.decrease_amount});
            case (it.func)
                FUNC_INSERT: begin
                    if (items_seen >= HEAP_DEPTH || occupied >= HEAP_DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        slot_key[occupied] = it.key;
                        slot_handle[occupied] = items_seen;
                        handle_pos[items_seen] = occupied;
                        handle_in_heap[items_seen] = 1'b1;
                        occupied++;
                        sift_up(occupied - 1);
                    end
                end
                FUNC_DECREASE: begin
                    if (it.target_item == 0 || it.target_item > HEAP_DEPTH ||
                            !handle_in_heap[it.target_item - 1]) begin
                        r.status = STATUS_NOT_LIVE;
                    end else begin
                        pos = handle_pos[it.target_item - 1];
                        k = slot_key[pos];
                        if (k < (64'sh8000_0000_0000_0000 + amt))
                            slot_key[pos] = 64'sh8000_0000_0000_0000;
                        else
                            slot_key[pos] = k - amt;
                        sift_up(pos);
                    end
                end
                FUNC_GET_MIN: begin
                    if (occupied == 0) r.status = STATUS_EMPTY;
                    else r.min_key = slot_key[0];
                end
                default: begin
                    if (occupied == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        last = occupied - 1;
                        handle_in_heap[slot_handle[0]] = 1'b0;
                        if (last != 0) begin
                            slot_key[0] = slot_key[last];
                            slot_handle[0] = slot_handle[last];
                            handle_pos[slot_handle[0]] = 0;
                        end
                        occupied = last;
                        sift_down(0);
                    end
                end
            endcase
            if (items_seen < HEAP_DEPTH) items_seen++;
            pending_results = {pending_results, r};
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result: min_key %0d status %0d", got.min_key, got.status);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.min_key !== exp_r.min_key) begin
                $error("min_key: expected %0d, actual %0d", exp_r.min_key, got.min_key);
                mismatches++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                mismatches++;
            end
        endfunction

        // Picks a handle that is still in the heap, as a 1-based item number, or 0 if none.
        function int pick_live_item();
            int tries;
            int h;
            if (occupied == 0) return 0;
            for (tries = 0; tries < 8; tries++) begin
                h = $urandom_range(occupied - 1);
                return slot_handle[h] + 1;
            end
            return 0;
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    heap_scoreboard heap_sb = new();

    int burst_left = 0;
    int idle_cycles = 0;

    always #1 aclk = ~aclk;

    indexed_min_heap_decrease_key_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The sender works in bursts. Between bursts it drops valid for a random gap, which may
    // be zero so that back-to-back stretches also occur. Valid is written once per edge.
    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        heap_sb.note_input(it);
    endtask

    function automatic in_item_t make_item(func_t f, logic signed [63:0] k, int tgt,
                                           logic [62:0] amt);
        in_item_t it;
        it.func = f;
        it.key = k;
        it.target_item = tgt[10:0];
        it.decrease_amount = amt;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys and amounts are mostly small so that decreases reorder the heap often; some span
    // the full range to reach saturation and the sign bit.
    function automatic in_item_t random_item();
        in_item_t    it;
        int          sel;
        logic [63:0] raw;
        sel = $urandom_range(99);
        raw = rand64();
        it.key = ($urandom_range(3) == 0) ? raw : longint'($urandom_range(2000)) - 1000;
        it.decrease_amount = ($urandom_range(4) == 0) ? 63'(rand64())
                                                      : 63'($urandom_range(600));
        it.target_item = 11'($urandom);
        if (sel < 35) begin
            it.func = FUNC_INSERT;
        end else if (sel < 65) begin
            it.func = FUNC_DECREASE;
            // Most decreases target a handle that is still in the heap.
            if ($urandom_range(9) < 8 && heap_sb.occupied > 0)
                it.target_item = 11'(heap_sb.pick_live_item());
        end else if (sel < 80) begin
            it.func = FUNC_GET_MIN;
        end else begin
            it.func = FUNC_EXTRACT;
        end
        return it;
    endfunction

    // The receiver steps through four stall styles in turn: always ready, periodically
    // stalled, coin flip, or long stalls.
    int rx_cycle = 0;
    int rx_hold = 0;
    always @(posedge aclk) begin
        if (m_valid && m_ready) heap_sb.check_result(m_data);
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 64) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= (rx_cycle % 3) != 0;
            2: m_ready <= 1'($urandom_range(1));
            default: begin
                if (rx_hold > 0) begin
                    rx_hold <= rx_hold - 1;
                    m_ready <= 1'b0;
                end else begin
                    rx_hold <= $urandom_range(12);
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog: a run with no transfer on either channel for too long is a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Item numbers start at 1, so the insert at item N is targeted as N.
        send_item(make_item(FUNC_GET_MIN, 0, 0, 0));                      // 1 empty heap
        send_item(make_item(FUNC_EXTRACT, 0, 0, 0));                      // 2 empty heap
        send_item(make_item(FUNC_INSERT, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 0)); // 3
        send_item(make_item(FUNC_INSERT, 64'sh8000_0000_0000_0000, 0, 0)); // 4
        send_item(make_item(FUNC_INSERT, 0, 0, 0));                       // 5
        send_item(make_item(FUNC_INSERT, -5, 0, 0));                      // 6
        send_item(make_item(FUNC_GET_MIN, 0, 0, 0));
        send_item(make_item(FUNC_DECREASE, 0, 3, '1));    // largest key minus largest amount
        send_item(make_item(FUNC_DECREASE, 0, 6, '1));    // saturates at the most negative key
        send_item(make_item(FUNC_DECREASE, 0, 0, 1));     // item zero is never a handle
        send_item(make_item(FUNC_DECREASE, 0, 2047, 1));  // beyond the handle space
        send_item(make_item(FUNC_DECREASE, 0, 1024, 1));  // not yet inserted
        send_item(make_item(FUNC_DECREASE, 0, 1, 1));     // item 1 was not an insert
        send_item(make_item(FUNC_DECREASE, 0, 5, 0));     // zero amount
        send_item(make_item(FUNC_GET_MIN, 0, 0, 0));
        send_item(make_item(FUNC_EXTRACT, 0, 0, 0));
        send_item(make_item(FUNC_DECREASE, 0, 4, 7));     // may hit the extracted handle
        send_item(make_item(FUNC_DECREASE, 0, 6, 7));
        repeat (5) send_item(make_item(FUNC_EXTRACT, 0, 0, 0));  // drain past empty
        send_item(make_item(FUNC_DECREASE, 0, 5, 1));     // extracted handle

        for (n = 0; n < 376; n++) send_item(random_item());

        s_valid <= 1'b0;
        while (heap_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (heap_sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/imhdk_pkg.sv
design/imhdk_ram.sv
design/imhdk_ctrl.sv
design/imhdk_dp.sv
design/indexed_min_heap_decrease_key_core.sv
sim/tb_top.sv
